FILE: hdl/svm_pkg.sv
`timescale 1ns / 1ps
package svm_pkg;

    localparam int MAX_VOICES   = 32;
    localparam int SAMPLE_DEPTH = 65536;

    localparam int VIDX_W  = $clog2(MAX_VOICES);
    localparam int CNT_W   = $clog2(MAX_VOICES + 1);
    localparam int SADDR_W = $clog2(SAMPLE_DEPTH);

    // Fixed field widths of the stream payload.
    localparam int KIND_W      = 2;
    localparam int ADDR_W      = 16;
    localparam int SAMPLE_W    = 16;
    localparam int LEN_W       = 17;
    localparam int VINDEX_W    = 5;
    localparam int FRAMES_W    = 13;
    localparam int OUT_COUNT_W = 6;
    localparam int POS_W       = 13;
    localparam int TOTAL_W     = 14;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 13'd2048;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX   = 13'd4096;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MIX  = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  cursor;
    } voice_t;

    typedef struct packed {
        logic              capture;
        logic              exec_load;
        logic              exec_play;
        logic              mix_start;
        logic              tbl_rd;
        logic [VIDX_W-1:0] rd_addr;
        logic              mix_issue;
        logic              copy_wr;
        logic [VIDX_W-1:0] wr_addr;
        logic              load_out;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VINDEX_W-1:0] vindex;
        logic [CNT_W-1:0]    count;
        logic                match;
        logic                buf_end;
        logic                out_free;
    } sts_t;

endpackage

FILE: hdl/svm_datapath.sv
`timescale 1ns / 1ps
module svm_datapath
    import svm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  cfg_wr_en,
    input  logic [FRAMES_W-1:0]   cfg_wr_data,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast
);

    voice_t                      voice_mem [MAX_VOICES];
    logic signed [SAMPLE_W-1:0]  sample_mem [SAMPLE_DEPTH];

    logic [KIND_W-1:0]          kind_reg;
    logic [ADDR_W-1:0]          address_reg;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic [LEN_W-1:0]           length_reg;
    logic [VINDEX_W-1:0]        vindex_reg;

    logic [FRAMES_W-1:0]        frames_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       had_reg, had_next;
    logic                       end_reg, end_next;

    voice_t                     rd_data_reg;
    logic                       s1_valid_reg;
    logic [VIDX_W-1:0]          s1_idx_reg;
    logic                       s2_valid_reg;
    logic signed [SAMPLE_W-1:0] smem_rd_reg;
    logic signed [SAMPLE_W-1:0] acc_reg, acc_next;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_had_reg;
    logic [OUT_COUNT_W-1:0]     out_count_reg;
    logic                       out_end_reg;

    logic                       live;
    logic [LEN_W:0]             addr_sum;
    logic [SADDR_W-1:0]         smem_rd_addr;
    logic [FRAMES_W-1:0]        frames_eff;
    logic [TOTAL_W-1:0]         total;
    logic signed [SAMPLE_W:0]   sum;
    voice_t                     play_entry;
    voice_t                     step_entry;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg    <= s_tuser;
            address_reg <= s_tdata[15:0];
            value_reg   <= s_tdata[31:16];
            length_reg  <= s_tdata[48:32];
            vindex_reg  <= s_tdata[53:49];
        end
    end

    // Frame count is clamped into 1..4096 before doubling into a sample total.
    always_comb
    begin
        if (frames_reg == '0)
            frames_eff = FRAMES_W'(1);
        else if (frames_reg > FRAMES_MAX)
            frames_eff = FRAMES_MAX;
        else
            frames_eff = frames_reg;
        total = {frames_eff, 1'b0};
    end

    always_comb
    begin
        pos_next = pos_reg;
        had_next = had_reg;
        end_next = end_reg;
        if (cmd.mix_start)
        begin
            if (pos_reg == '0)
                had_next = (count_reg != '0);
            end_next = ((TOTAL_W'(pos_reg) + TOTAL_W'(1)) >= total);
            pos_next = end_next ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.exec_play)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.copy_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_RESET;
            count_reg  <= '0;
            pos_reg    <= '0;
            had_reg    <= 1'b0;
            end_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                frames_reg <= cfg_wr_data;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            had_reg   <= had_next;
            end_reg   <= end_next;
        end
    end

    // Voice table: one write and one registered read per cycle.
    always_comb
    begin
        live           = (rd_data_reg.cursor < rd_data_reg.length);
        addr_sum       = (LEN_W + 1)'(rd_data_reg.base) + (LEN_W + 1)'(rd_data_reg.cursor);
        smem_rd_addr   = SADDR_W'(addr_sum);
        play_entry     = '{base: address_reg, length: length_reg, cursor: '0};
        step_entry     = rd_data_reg;
        step_entry.cursor = rd_data_reg.cursor + LEN_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && live)
            voice_mem[s1_idx_reg] <= step_entry;
        else if (cmd.exec_play)
            voice_mem[count_reg[VIDX_W-1:0]] <= play_entry;
        else if (cmd.copy_wr)
            voice_mem[cmd.wr_addr] <= rd_data_reg;
        if (cmd.tbl_rd)
            rd_data_reg <= voice_mem[cmd.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_load)
            sample_mem[SADDR_W'(address_reg)] <= value_reg;
        smem_rd_reg <= sample_mem[smem_rd_addr];
        s1_idx_reg  <= cmd.rd_addr;
    end

    always_comb
    begin
        sum      = {acc_reg[SAMPLE_W-1], acc_reg} + {smem_rd_reg[SAMPLE_W-1], smem_rd_reg};
        acc_next = acc_reg;
        if (cmd.mix_start)
            acc_next = '0;
        else if (s2_valid_reg)
        begin
            if (sum > (SAMPLE_W + 1)'(SAT_MAX))
                acc_next = SAT_MAX;
            else if (sum < (SAMPLE_W + 1)'(SAT_MIN))
                acc_next = SAT_MIN;
            else
                acc_next = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd.mix_issue;
            s2_valid_reg <= s1_valid_reg && live;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_sample_reg <= acc_reg;
            out_had_reg    <= had_reg;
            out_count_reg  <= OUT_COUNT_W'(count_reg);
            out_end_reg    <= end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_had_reg, out_sample_reg};
    assign m_tlast  = out_end_reg;

    assign sts.kind     = kind_reg;
    assign sts.vindex   = vindex_reg;
    assign sts.count    = count_reg;
    assign sts.match    = (rd_data_reg.cursor == rd_data_reg.length);
    assign sts.buf_end  = end_reg;
    assign sts.out_free = !out_valid_reg || m_tready;

endmodule

FILE: hdl/svm_ctrl.sv
`timescale 1ns / 1ps
module svm_ctrl
    import svm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_EXEC   = 4'd1;
    localparam logic [3:0] ST_STOPWR = 4'd2;
    localparam logic [3:0] ST_ISSUE  = 4'd3;
    localparam logic [3:0] ST_DRAIN1 = 4'd4;
    localparam logic [3:0] ST_DRAIN2 = 4'd5;
    localparam logic [3:0] ST_SWRD   = 4'd6;
    localparam logic [3:0] ST_SWCHK  = 4'd7;
    localparam logic [3:0] ST_SWWR   = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] last;
    logic             stop_ok;

    assign last    = sts.count - CNT_W'(1);
    assign stop_ok = (CNT_W'(sts.vindex) < sts.count);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                unique case (sts.kind)
                    KIND_LOAD: cmd.exec_load = 1'b1;
                    KIND_PLAY: cmd.exec_play = (sts.count < CNT_W'(MAX_VOICES));
                    KIND_STOP:
                    begin
                        if (stop_ok)
                        begin
                            cmd.tbl_rd  = 1'b1;
                            cmd.rd_addr = last[VIDX_W-1:0];
                            state_next  = ST_STOPWR;
                        end
                    end
                    KIND_MIX:
                    begin
                        cmd.mix_start = 1'b1;
                        idx_next      = '0;
                        state_next    = ST_ISSUE;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_STOPWR:
            begin
                cmd.copy_wr = 1'b1;
                cmd.wr_addr = VIDX_W'(sts.vindex);
                state_next  = ST_IDLE;
            end
            ST_ISSUE:
            begin
                // One table read per cycle; a sample fetch and an add follow it.
                if (idx_reg < sts.count)
                begin
                    cmd.tbl_rd    = 1'b1;
                    cmd.rd_addr   = idx_reg[VIDX_W-1:0];
                    cmd.mix_issue = 1'b1;
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else
                    state_next = ST_DRAIN1;
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2:
            begin
                idx_next   = sts.count;
                state_next = sts.buf_end ? ST_SWRD : ST_FIN;
            end
            ST_SWRD:
            begin
                // The sweep walks the table from the highest slot down.
                if (idx_reg == '0)
                    state_next = ST_FIN;
                else
                begin
                    cmd.tbl_rd  = 1'b1;
                    cmd.rd_addr = VIDX_W'(idx_reg - CNT_W'(1));
                    idx_next    = idx_reg - CNT_W'(1);
                    state_next  = ST_SWCHK;
                end
            end
            ST_SWCHK:
            begin
                if (sts.match)
                begin
                    cmd.tbl_rd  = 1'b1;
                    cmd.rd_addr = last[VIDX_W-1:0];
                    state_next  = ST_SWWR;
                end
                else
                    state_next = ST_SWRD;
            end
            ST_SWWR:
            begin
                cmd.copy_wr = 1'b1;
                cmd.wr_addr = idx_reg[VIDX_W-1:0];
                state_next  = ST_SWRD;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

FILE: hdl/saturating_voice_mixer_top.sv
`timescale 1ns / 1ps
// Saturating voice mixer.
// Items arrive on the s_ stream: tuser carries the item kind (load a sample,
// play a voice, stop a voice, mix one output sample). Only mix items produce a
// beat on the m_ stream, with tlast set on the last sample of a buffer.
// The frame count register is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while idle; the block itself does not enforce this.
// One item is worked on at a time. Load, play and an ignored stop pass through
// an execute state before the next ready; a stop that removes a voice adds a
// copy-write state. A mix reads one voice table entry per cycle through a
// three-stage read, fetch and add pipeline, then drains it. At a buffer end, a
// sweep reads and checks each voice from the top slot down and copies the last
// voice over each removed one.
// Reset empties the voice table, rewinds the buffer position and sets the
// frame count to 2048; sample memory holds nothing until loaded.
// A result sits in an output register, so a stalled receiver holds up the
// block only when the next mix result is ready before the previous one left.
module saturating_voice_mixer_top
    import svm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // address[15:0], sample_value[31:16], length[48:32], voice_index[53:49]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // mixed_sample[15:0], voices_present[16], voice_count[22:17]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [FRAMES_W-1:0]  cfg_wr_data
);

    cmd_t cmd;
    sts_t sts;

    svm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    svm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sts.count <= CNT_W'(MAX_VOICES))
        else $error("voice count above table size");

    a_play_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec_play |-> sts.count < CNT_W'(MAX_VOICES))
        else $error("play appended to a full table");

    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_wr |-> sts.count != '0)
        else $error("voice removed from an empty table");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result register overwritten before it was taken");
`endif

endmodule

FILE: tb/sv/saturating_voice_mixer_top_tb.sv
`timescale 1ns / 1ps
module saturating_voice_mixer_top_tb;
    import svm_pkg::*;

    localparam int SETTLE_CYCLES = 200;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] sval;
        logic [LEN_W-1:0]    len;
        logic [VINDEX_W-1:0] vidx;
    } mixer_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed;
        logic                       present;
        logic [OUT_COUNT_W-1:0]     count;
        logic                       last;
    } mix_out_t;

    typedef struct packed {
        mixer_item_t item;
        logic        typed;
        mix_out_t    want;
    } stim_row_t;

    typedef struct packed {
        logic [FRAMES_W-1:0] frames;
        int                  items;
        int                  load_pct;
        int                  play_pct;
        int                  stop_pct;
        logic                long_voices;
        logic                quiet;
        logic                hold;
    } phase_t;

    localparam mix_out_t NO_WANT = '0;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = KIND_LOAD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [FRAMES_W-1:0]  cfg_wr_data = '0;

    // Mirror of the mixer state, advanced as each beat is accepted.
    logic [SAMPLE_W-1:0] sample_store [SAMPLE_DEPTH];
    bit                  sample_loaded [SAMPLE_DEPTH];
    logic [ADDR_W-1:0]   slot_base [MAX_VOICES];
    logic [LEN_W-1:0]    slot_len [MAX_VOICES];
    logic [LEN_W-1:0]    slot_pos [MAX_VOICES];
    int                  voices_playing = 0;
    int                  buffer_pos = 0;
    logic                buffer_had_voices = 1'b0;
    logic [FRAMES_W-1:0] frames_setting = FRAMES_RESET;

    mix_out_t mix_expect_q [$];

    int  errors = 0;
    int  items_sent = 0;
    int  beats_checked = 0;
    int  buffer_ends_seen = 0;
    int  clipped_mixes = 0;
    int  refused_plays = 0;
    int  refused_stops = 0;
    int  peak_voices = 0;
    int  frame_writes = 0;
    bit  sender_quiet = 1'b0;
    bit  receiver_quiet = 1'b0;
    bit  hold_request = 1'b0;

    stim_row_t directed_rows [25] = '{
        '{'{KIND_MIX,  16'h0000, 16'h0000, 17'd0,     5'd0},  1'b1,
          '{16'sh0000, 1'b0, 6'd0, 1'b0}},
        '{'{KIND_LOAD, 16'h0000, 16'h7FFF, 17'd0,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_LOAD, 16'hFFFF, 16'h7FFF, 17'd0,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_LOAD, 16'h0001, 16'h8000, 17'd0,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_LOAD, 16'h0002, 16'h8000, 17'd0,     5'd0},  1'b0, NO_WANT},
        // This voice wraps from the top of the sample store back to address zero.
        '{'{KIND_PLAY, 16'hFFFF, 16'h0000, 17'd2,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_PLAY, 16'h0000, 16'h0000, 17'd1,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_PLAY, 16'h0000, 16'h0000, 17'd0,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_PLAY, 16'h0001, 16'h0000, 17'd2,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_MIX,  16'h0000, 16'h0000, 17'd0,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_MIX,  16'h0000, 16'h0000, 17'd0,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_MIX,  16'h0000, 16'h0000, 17'd0,     5'd0},  1'b1,
          '{16'sh0000, 1'b0, 6'd4, 1'b0}},
        '{'{KIND_PLAY, 16'h0001, 16'h0000, 17'd2,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_PLAY, 16'h0001, 16'h0000, 17'd2,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_MIX,  16'h0000, 16'h0000, 17'd0,     5'd0},  1'b1,
          '{SAT_MIN, 1'b0, 6'd6, 1'b0}},
        '{'{KIND_MIX,  16'h0000, 16'h0000, 17'd0,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_STOP, 16'h0000, 16'h0000, 17'd0,     5'd31}, 1'b0, NO_WANT},
        '{'{KIND_STOP, 16'h0000, 16'h0000, 17'd0,     5'd6},  1'b0, NO_WANT},
        '{'{KIND_STOP, 16'h0000, 16'h0000, 17'd0,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_LOAD, 16'hAAAA, 16'h5555, 17'd0,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_LOAD, 16'h5555, 16'hAAAA, 17'd0,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_PLAY, 16'hAAAA, 16'h0000, 17'h10000, 5'd0},  1'b0, NO_WANT},
        '{'{KIND_MIX,  16'h0000, 16'h0000, 17'd0,     5'd0},  1'b0, NO_WANT},
        '{'{KIND_STOP, 16'h0000, 16'h0000, 17'd0,     5'd5},  1'b0, NO_WANT},
        '{'{KIND_MIX,  16'h0000, 16'h0000, 17'd0,     5'd0},  1'b1,
          '{16'sh0000, 1'b0, 6'd5, 1'b0}}
    };

    // A frame count of 0 and one above 4096 check the clamping; switching
    // from a long buffer to a short one lands the position past the end.
    phase_t phase_plan [10] = '{
        '{13'd1,    120, 15, 25, 10, 1'b0, 1'b0, 1'b0},
        '{13'd0,    100, 15, 25, 10, 1'b0, 1'b1, 1'b0},
        '{13'd3,    150, 10, 60,  5, 1'b1, 1'b0, 1'b1},
        '{13'd8191, 100, 15, 15, 25, 1'b0, 1'b0, 1'b0},
        '{13'd2,    120, 15, 20, 20, 1'b0, 1'b0, 1'b0},
        '{13'd4096,  80, 15, 25, 10, 1'b0, 1'b1, 1'b0},
        '{13'd5,    150, 10, 25, 20, 1'b0, 1'b0, 1'b1},
        '{13'd4097,  50, 15, 25, 15, 1'b0, 1'b0, 1'b0},
        '{13'd1,    100, 15, 30, 10, 1'b0, 1'b1, 1'b0},
        '{13'd7,     80, 15, 25, 15, 1'b0, 1'b0, 1'b0}
    };

    saturating_voice_mixer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(20_000_000);
        $display("FAIL");
        $finish;
    end

    function automatic void drop_slot(input int slot);
        int last_slot;
        if (slot < voices_playing)
        begin
            last_slot = voices_playing - 1;
            slot_base[slot] = slot_base[last_slot];
            slot_len[slot]  = slot_len[last_slot];
            slot_pos[slot]  = slot_pos[last_slot];
            voices_playing  = last_slot;
        end
    endfunction

    // Returns 1 when the item produces an output beat, which is left in res.
    function automatic bit mixer_predict(input mixer_item_t it, output mix_out_t res);
        int                frames;
        int                total;
        int                acc;
        int                i;
        bit                clipped;
        bit                ends;
        logic [ADDR_W-1:0] a;
        res = '0;
        if (it.kind == KIND_LOAD)
        begin
            sample_store[it.addr] = it.sval;
            sample_loaded[it.addr] = 1'b1;
            return 1'b0;
        end
        if (it.kind == KIND_PLAY)
        begin
            if (voices_playing < MAX_VOICES)
            begin
                slot_base[voices_playing] = it.addr;
                slot_len[voices_playing]  = it.len;
                slot_pos[voices_playing]  = '0;
                voices_playing++;
                if (voices_playing > peak_voices)
                    peak_voices = voices_playing;
            end
            else
                refused_plays++;
            return 1'b0;
        end
        if (it.kind == KIND_STOP)
        begin
            if (it.vidx >= voices_playing)
                refused_stops++;
            drop_slot(it.vidx);
            return 1'b0;
        end

        frames = int'(frames_setting);
        if (frames < 1)
            frames = 1;
        if (frames > FRAMES_MAX)
            frames = int'(FRAMES_MAX);
        total = 2 * frames;
        if (buffer_pos == 0)
            buffer_had_voices = (voices_playing != 0);

        acc = 0;
        clipped = 1'b0;
        for (i = 0; i < voices_playing; i++)
        begin
            if (slot_pos[i] < slot_len[i])
            begin
                a = slot_base[i] + slot_pos[i][ADDR_W-1:0];
                acc = acc + $signed(sample_store[a]);
                if (acc > SAT_MAX)
                begin
                    acc = int'(SAT_MAX);
                    clipped = 1'b1;
                end
                if (acc < SAT_MIN)
                begin
                    acc = int'(SAT_MIN);
                    clipped = 1'b1;
                end
                slot_pos[i] = slot_pos[i] + 1'b1;
            end
        end
        if (clipped)
            clipped_mixes++;

        ends = (buffer_pos + 1 >= total);
        if (ends)
        begin
            // Sweep from the top so a moved voice has already been looked at.
            for (i = voices_playing - 1; i >= 0; i--)
            begin
                if (slot_pos[i] == slot_len[i])
                    drop_slot(i);
            end
            buffer_pos = 0;
        end
        else
            buffer_pos = buffer_pos + 1;

        res.mixed   = acc[SAMPLE_W-1:0];
        res.present = buffer_had_voices;
        res.count   = voices_playing[OUT_COUNT_W-1:0];
        res.last    = ends;
        return 1'b1;
    endfunction

    task automatic send_item(input mixer_item_t it, input bit use_typed,
                             input mix_out_t typed_res);
        mix_out_t res;
        int       gap;
        int       roll;
        gap = 0;
        if (!sender_quiet)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 92)
                gap = $urandom_range(12, 60);
            else if (roll >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {2'b00, it.vidx, it.len, it.sval, it.addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (mixer_predict(it, res))
            mix_expect_q.push_back(use_typed ? typed_res : res);
    endtask

    // Every sample a mix is about to read gets loaded first if it never was.
    task automatic load_missing_samples(output int sent);
        mixer_item_t       fill;
        logic [ADDR_W-1:0] a;
        int                i;
        sent = 0;
        for (i = 0; i < voices_playing; i++)
        begin
            a = slot_base[i] + slot_pos[i][ADDR_W-1:0];
            if (slot_pos[i] < slot_len[i] && !sample_loaded[a])
            begin
                fill.kind = KIND_LOAD;
                fill.addr = a;
                fill.sval = SAMPLE_W'($urandom);
                fill.len  = LEN_W'($urandom_range(0, 65536));
                fill.vidx = VINDEX_W'($urandom);
                send_item(fill, 1'b0, NO_WANT);
                sent++;
            end
        end
    endtask

    task automatic drain_results();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (mix_expect_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        // Load, play and stop leave no beat behind, so give the block time.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : receiver
        int run;
        int stall;
        int roll;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= 1'b1;
            roll = $urandom_range(0, 99);
            run = (roll < 15) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            if (!receiver_quiet)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    stall = $urandom_range(1, 2);
                else if (roll < 95)
                    stall = $urandom_range(3, 10);
                else
                    stall = $urandom_range(20, 60);
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : beat_check
        mix_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (mix_expect_q.size() == 0)
            begin
                $error("unexpected output beat: mixed_sample %0d", $signed(m_tdata[15:0]));
                errors++;
            end
            else
            begin
                want = mix_expect_q.pop_front();
                beats_checked++;
                if (want.last)
                    buffer_ends_seen++;
                if (m_tdata[15:0] !== want.mixed)
                begin
                    $error("mixed_sample: expected %0d, actual %0d",
                           want.mixed, $signed(m_tdata[15:0]));
                    errors++;
                end
                if (m_tdata[16] !== want.present)
                begin
                    $error("voices_present: expected %0d, actual %0d",
                           want.present, m_tdata[16]);
                    errors++;
                end
                if (m_tdata[22:17] !== want.count)
                begin
                    $error("voice_count: expected %0d, actual %0d", want.count, m_tdata[22:17]);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("buffer_end: expected %0d, actual %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        mixer_item_t it;
        int          r;
        int          p;
        int          sent;
        int          extra;
        int          roll;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        for (r = 0; r < $size(directed_rows); r++)
        begin
            if (directed_rows[r].item.kind == KIND_MIX)
                load_missing_samples(extra);
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        end

        for (p = 0; p < $size(phase_plan); p++)
        begin
            drain_results();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= phase_plan[p].frames;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            frames_setting = phase_plan[p].frames;
            frame_writes++;

            sender_quiet   = phase_plan[p].quiet;
            receiver_quiet = phase_plan[p].quiet;
            hold_request   = phase_plan[p].hold;
            sent = 0;
            while (sent < phase_plan[p].items)
            begin
                // Fields the kind does not use still carry random bits.
                it.addr = ADDR_W'($urandom);
                it.sval = SAMPLE_W'($urandom);
                it.len  = LEN_W'($urandom_range(0, 65536));
                it.vidx = VINDEX_W'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < phase_plan[p].load_pct)
                begin
                    it.kind = KIND_LOAD;
                    if ($urandom_range(0, 1))
                        it.addr = ADDR_W'($urandom_range(0, 2047));
                    if ($urandom_range(0, 9) == 0)
                        it.sval = $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
                end
                else if (roll < phase_plan[p].load_pct + phase_plan[p].play_pct)
                begin
                    it.kind = KIND_PLAY;
                    if ($urandom_range(0, 99) < 70)
                        it.addr = ADDR_W'($urandom_range(0, 2047));
                    roll = $urandom_range(0, 99);
                    if (phase_plan[p].long_voices && roll < 80)
                        it.len = LEN_W'($urandom_range(200, 600));
                    else if (roll < 70)
                        it.len = LEN_W'($urandom_range(0, 12));
                    else if (roll < 90)
                        it.len = LEN_W'($urandom_range(13, 200));
                    else if (roll < 98)
                        it.len = LEN_W'($urandom_range(201, 5000));
                    else
                        it.len = LEN_W'($urandom_range(60000, 65536));
                end
                else if (roll < phase_plan[p].load_pct + phase_plan[p].play_pct
                                + phase_plan[p].stop_pct)
                begin
                    it.kind = KIND_STOP;
                    if (voices_playing > 0 && $urandom_range(0, 99) < 75)
                        it.vidx = VINDEX_W'($urandom_range(0, voices_playing - 1));
                end
                else
                begin
                    it.kind = KIND_MIX;
                    load_missing_samples(extra);
                    sent += extra;
                end
                send_item(it, 1'b0, NO_WANT);
                sent++;
            end
        end

        drain_results();
        if (mix_expect_q.size() != 0)
        begin
            $error("%0d expected mix beats never arrived", mix_expect_q.size());
            errors++;
        end
        $display("Sent %0d items under %0d frame-count settings; checked %0d mix beats,",
                 items_sent, frame_writes + 1, beats_checked);
        $display("%0d of them buffer ends, %0d clipped; refused plays %0d, bad stops %0d, peak %0d.",
                 buffer_ends_seen, clipped_mixes, refused_plays, refused_stops, peak_voices);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
